@@ hw/rtl/tga_hss_pkg.sv @@
// Shared types, constants and register map of the TGA header stream scanner.
`timescale 1ns / 1ps

package tga_hss_pkg;

  // Position counter width default and header geometry
  localparam int OFFSET_BITS_DEF = 32;
  localparam int HDR_LEN         = 18;

  // Result queue depth; an end-of-file byte may push two results at once
  localparam int QDEPTH = 4;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // APB register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SCAN_START  = 3'd0,
    REG_MAX_MATCHES = 3'd1,
    REG_MIN_DIM     = 3'd2,
    REG_MAX_DIM     = 3'd3,
    REG_MAX_ID_LEN  = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [31:0] SCAN_START_RST  = 32'd3843;
  localparam logic [7:0]  MAX_MATCHES_RST = 8'd15;
  localparam logic [15:0] MIN_DIM_RST     = 16'd16;
  localparam logic [15:0] MAX_DIM_RST     = 16'd1024;
  localparam logic [7:0]  MAX_ID_LEN_RST  = 8'd32;

  // Header field codes accepted by the scan
  localparam logic [7:0] CMAP_NONE     = 8'd0;
  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;
  localparam logic [7:0] BPP_24        = 8'd24;
  localparam logic [7:0] BPP_32        = 8'd32;
  localparam logic [3:0] DESC_ORIGIN_BL = 4'h0;
  localparam logic [3:0] DESC_ALPHA_8   = 4'h8;

  // Result kind codes
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [31:0] scan_start_offset;
    logic [7:0]  max_matches;
    logic [15:0] min_dimension;
    logic [15:0] max_dimension;
    logic [7:0]  max_id_length;
  } cfg_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] header_offset;
    logic [7:0]  image_type;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits_per_pixel;
    logic [7:0]  match_total;
    logic        final_result;
  } result_t;

endpackage

@@ hw/rtl/tga_hss_regs.sv @@
// APB configuration registers of the TGA header stream scanner.
`timescale 1ns / 1ps

module tga_hss_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tga_hss_pkg::ADDR_W-1:0]   paddr,
  input  logic [tga_hss_pkg::DATA_W-1:0]   pwdata,
  output logic [tga_hss_pkg::DATA_W-1:0]   prdata,
  output logic                             pready,
  output tga_hss_pkg::cfg_t                cfg
);

  logic                    wr_en;
  tga_hss_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = tga_hss_pkg::reg_idx_t'(paddr[tga_hss_pkg::ADDR_W-1:2]);

  // Write the addressed register; addresses beyond the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_start_offset <= tga_hss_pkg::SCAN_START_RST;
      cfg.max_matches       <= tga_hss_pkg::MAX_MATCHES_RST;
      cfg.min_dimension     <= tga_hss_pkg::MIN_DIM_RST;
      cfg.max_dimension     <= tga_hss_pkg::MAX_DIM_RST;
      cfg.max_id_length     <= tga_hss_pkg::MAX_ID_LEN_RST;
    end else if (wr_en) begin
      case (idx)
        tga_hss_pkg::REG_SCAN_START:  cfg.scan_start_offset <= pwdata;
        tga_hss_pkg::REG_MAX_MATCHES: cfg.max_matches       <= pwdata[7:0];
        tga_hss_pkg::REG_MIN_DIM:     cfg.min_dimension     <= pwdata[15:0];
        tga_hss_pkg::REG_MAX_DIM:     cfg.max_dimension     <= pwdata[15:0];
        tga_hss_pkg::REG_MAX_ID_LEN:  cfg.max_id_length     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      tga_hss_pkg::REG_SCAN_START:  prdata = cfg.scan_start_offset;
      tga_hss_pkg::REG_MAX_MATCHES: prdata = {24'd0, cfg.max_matches};
      tga_hss_pkg::REG_MIN_DIM:     prdata = {16'd0, cfg.min_dimension};
      tga_hss_pkg::REG_MAX_DIM:     prdata = {16'd0, cfg.max_dimension};
      tga_hss_pkg::REG_MAX_ID_LEN:  prdata = {24'd0, cfg.max_id_length};
      default:                      prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/tga_hss_scan.sv @@
// Byte history, position and match count, and the header candidate test.
`timescale 1ns / 1ps

module tga_hss_scan #(
  parameter int OFFSET_BITS = tga_hss_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_file,
  input  logic                 end_of_file,
  input  tga_hss_pkg::cfg_t    cfg,
  output logic [1:0]           res_count,
  output tga_hss_pkg::result_t res0,
  output tga_hss_pkg::result_t res1
);

  localparam int CmpW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  logic [OFFSET_BITS-1:0] position;
  logic [7:0]             match_counter;
  logic [7:0]             hist [tga_hss_pkg::HDR_LEN];

  logic [OFFSET_BITS-1:0] pos_cur;
  logic [OFFSET_BITS-1:0] position_next;
  logic [7:0]             mc_cur;
  logic [7:0]             match_counter_next;
  logic [CmpW-1:0]        pos_ext;
  logic [CmpW-1:0]        cand_off;
  logic                   in_window;
  logic [7:0]             id_len;
  logic [7:0]             cmap;
  logic [7:0]             itype;
  logic [15:0]            width;
  logic [15:0]            height;
  logic [7:0]             bpp;
  logic [3:0]             nib;
  logic                   hdr_ok;
  logic                   hit;
  tga_hss_pkg::result_t   match_res;
  tga_hss_pkg::result_t   sum_res;

  // Start of file restarts position and count for this byte
  always_comb begin
    pos_cur  = start_of_file ? '0 : position;
    mc_cur   = start_of_file ? '0 : match_counter;
    pos_ext  = CmpW'(pos_cur);
    cand_off = pos_ext - CmpW'(tga_hss_pkg::HDR_LEN);
    in_window = (pos_ext >= CmpW'(tga_hss_pkg::HDR_LEN)) &&
                (cand_off >= CmpW'(cfg.scan_start_offset)) &&
                (mc_cur < cfg.max_matches);
    position_next = (pos_cur != '1) ? pos_cur + 1'b1 : pos_cur;
  end

  // Test the 18 stored bytes as a header
  always_comb begin
    id_len = hist[0];
    cmap   = hist[1];
    itype  = hist[2];
    width  = {hist[13], hist[12]};
    height = {hist[15], hist[14]};
    bpp    = hist[16];
    nib    = hist[17][3:0];
    hdr_ok = (cmap == tga_hss_pkg::CMAP_NONE) &&
             ((itype == tga_hss_pkg::TYPE_TRUECOLOR) ||
              (itype == tga_hss_pkg::TYPE_RLE_TRUECOLOR)) &&
             (id_len <= cfg.max_id_length) &&
             (width >= cfg.min_dimension) && (width <= cfg.max_dimension) &&
             (height >= cfg.min_dimension) && (height <= cfg.max_dimension) &&
             ((bpp == tga_hss_pkg::BPP_24) || (bpp == tga_hss_pkg::BPP_32)) &&
             ((nib == tga_hss_pkg::DESC_ORIGIN_BL) || (nib == tga_hss_pkg::DESC_ALPHA_8));
    hit = in_window && hdr_ok;
    match_counter_next = hit ? mc_cur + 8'd1 : mc_cur;
  end

  // Build the match report and the end-of-file summary
  always_comb begin
    match_res.result_kind    = tga_hss_pkg::KIND_MATCH;
    match_res.header_offset  = cand_off[31:0];
    match_res.image_type     = itype;
    match_res.image_width    = width;
    match_res.image_height   = height;
    match_res.bits_per_pixel = bpp;
    match_res.match_total    = match_counter_next;
    match_res.final_result   = ~end_of_file;

    sum_res.result_kind    = tga_hss_pkg::KIND_SUMMARY;
    sum_res.header_offset  = '0;
    sum_res.image_type     = '0;
    sum_res.image_width    = '0;
    sum_res.image_height   = '0;
    sum_res.bits_per_pixel = '0;
    sum_res.match_total    = match_counter_next;
    sum_res.final_result   = 1'b1;

    res0      = hit ? match_res : sum_res;
    res1      = sum_res;
    res_count = {1'b0, hit} + {1'b0, end_of_file};
  end

  // Advance position and count on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      match_counter <= '0;
    end else if (in_fire) begin
      position      <= position_next;
      match_counter <= match_counter_next;
    end
  end

  // Shift the byte history; entry 0 is the oldest byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < tga_hss_pkg::HDR_LEN - 1; i++) begin
        hist[i] <= hist[i+1];
      end
      hist[tga_hss_pkg::HDR_LEN-1] <= data_byte;
    end
  end

endmodule

@@ hw/rtl/tga_hss_outq.sv @@
// Small shifting result queue that takes up to two results per cycle.
`timescale 1ns / 1ps

module tga_hss_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  tga_hss_pkg::result_t push0,
  input  tga_hss_pkg::result_t push1,
  input  logic                 pop,
  output logic                 has_room,
  output logic                 head_valid,
  output tga_hss_pkg::result_t head
);

  localparam int QD = tga_hss_pkg::QDEPTH;
  localparam int CW = tga_hss_pkg::QCNT_W;

  tga_hss_pkg::result_t q [QD];
  tga_hss_pkg::result_t q_next [QD];
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        base;
  logic                 do_pop;

  assign head_valid = (count != '0);
  assign head       = q[0];
  assign has_room   = (count <= CW'(QD - 2));
  assign do_pop     = pop & head_valid;

  // Shift out the head on pop, then place new results behind the survivors
  always_comb begin
    base = do_pop ? count - 1'b1 : count;
    for (int i = 0; i < QD; i++) begin
      if (do_pop && (i < QD - 1)) begin
        q_next[i] = q[i+1];
      end else begin
        q_next[i] = q[i];
      end
      if ((push_count != 2'd0) && (CW'(i) == base)) begin
        q_next[i] = push0;
      end
      if ((push_count == 2'd2) && (CW'(i) == base + 1'b1)) begin
        q_next[i] = push1;
      end
    end
    count_next = base + CW'(push_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

@@ hw/rtl/tga_header_stream_scanner_core.sv @@
// Top level of the TGA header stream scanner: stream ports, APB port and wiring.
`timescale 1ns / 1ps

// Scans a file one byte per item and reports each true-color TGA header it finds.
// A byte is taken every cycle while the queue has room: the header test on the 18
// stored bytes is combinational and its results go into a four-entry result queue.
// The input stalls only when that queue holds more than two results, which happens
// when the output side stalls; an end-of-file byte pushes up to two results (a match,
// if any, then the summary) in the same cycle. A result is registered in the queue.

module tga_header_stream_scanner_core #(
  parameter int OFFSET_BITS = tga_hss_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] data_byte
  input  logic                           s_tuser,  // [0] start_of_file
  input  logic                           s_tlast,  // end_of_file
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] header_offset, [39:32] image_type, [55:40] image_width,
  // [71:56] image_height, [79:72] bits_per_pixel, [87:80] match_total
  output logic [87:0]                    m_tdata,
  output logic                           m_tuser,  // [0] result_kind
  output logic                           m_tlast,  // final_result
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tga_hss_pkg::ADDR_W-1:0] paddr,
  input  logic [tga_hss_pkg::DATA_W-1:0] pwdata,
  output logic [tga_hss_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);

  tga_hss_pkg::cfg_t    cfg;
  logic                 in_fire;
  logic                 has_room;
  logic [1:0]           res_count;
  logic [1:0]           push_count;
  tga_hss_pkg::result_t res0;
  tga_hss_pkg::result_t res1;
  tga_hss_pkg::result_t head;

  assign s_tready   = has_room;
  assign in_fire    = s_tvalid & s_tready;
  assign push_count = in_fire ? res_count : 2'd0;

  tga_hss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tga_hss_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .data_byte     (s_tdata),
    .start_of_file (s_tuser),
    .end_of_file   (s_tlast),
    .cfg           (cfg),
    .res_count     (res_count),
    .res0          (res0),
    .res1          (res1)
  );

  tga_hss_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (m_tready),
    .has_room   (has_room),
    .head_valid (m_tvalid),
    .head       (head)
  );

  // Pack the head result onto the output stream
  assign m_tdata = {head.match_total, head.bits_per_pixel, head.image_height,
                    head.image_width, head.image_type, head.header_offset};
  assign m_tuser = head.result_kind;
  assign m_tlast = head.final_result;

endmodule

@@ dv/tga_scan_check_pkg.sv @@
// Expected-report tracker for the TGA header stream scanner testbench.
`timescale 1ns / 1ps

package tga_scan_check_pkg;
  import tga_hss_pkg::*;

  localparam int WIN_LEN = HDR_LEN + 1;

  class header_hit_tracker;
    cfg_t            cfg;
    logic [7:0]      window [WIN_LEN];
    longint unsigned next_pos;
    longint unsigned pos_max;
    logic [7:0]      hit_count;
    result_t         expected_reports [$];
    int              mismatches;

    function new(int pos_bits);
      pos_max = (64'd1 << pos_bits) - 1;
      cfg.scan_start_offset = SCAN_START_RST;
      cfg.max_matches       = MAX_MATCHES_RST;
      cfg.min_dimension     = MIN_DIM_RST;
      cfg.max_dimension     = MAX_DIM_RST;
      cfg.max_id_length     = MAX_ID_LEN_RST;
      mismatches = 0;
      restart();
    endfunction

    // Clear position, window and hit count
    function void restart();
      foreach (window[i]) window[i] = '0;
      next_pos  = 0;
      hit_count = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_SCAN_START:  cfg.scan_start_offset = value;
        REG_MAX_MATCHES: cfg.max_matches       = value[7:0];
        REG_MIN_DIM:     cfg.min_dimension     = value[15:0];
        REG_MAX_DIM:     cfg.max_dimension     = value[15:0];
        REG_MAX_ID_LEN:  cfg.max_id_length     = value[7:0];
        default: ;
      endcase
    endfunction

    // Take one accepted byte: shift it in, test the 18 bytes before it, queue reports
    function void take_byte(logic [7:0] data, logic sof, logic eof);
      result_t         r;
      longint unsigned p;
      logic [15:0]     w;
      logic [15:0]     h;
      logic [3:0]      nib;
      bit              ok;
      if (sof) restart();
      for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i + 1];
      window[WIN_LEN - 1] = data;
      p   = next_pos;
      w   = {window[13], window[12]};
      h   = {window[15], window[14]};
      nib = window[17][3:0];
      ok = p >= HDR_LEN && (p - HDR_LEN) >= cfg.scan_start_offset &&
           hit_count < cfg.max_matches &&
           window[1] == CMAP_NONE &&
           (window[2] == TYPE_TRUECOLOR || window[2] == TYPE_RLE_TRUECOLOR) &&
           window[0] <= cfg.max_id_length &&
           w >= cfg.min_dimension && w <= cfg.max_dimension &&
           h >= cfg.min_dimension && h <= cfg.max_dimension &&
           (window[16] == BPP_24 || window[16] == BPP_32) &&
           (nib == DESC_ORIGIN_BL || nib == DESC_ALPHA_8);
      if (ok) begin
        hit_count++;
        r = '0;
        r.result_kind    = KIND_MATCH;
        r.header_offset  = 32'(p - HDR_LEN);
        r.image_type     = window[2];
        r.image_width    = w;
        r.image_height   = h;
        r.bits_per_pixel = window[16];
        r.match_total    = hit_count;
        r.final_result   = !eof;
        expected_reports.push_back(r);
      end
      // The summary follows any match of the same byte
      if (eof) begin
        r = '0;
        r.result_kind  = KIND_SUMMARY;
        r.match_total  = hit_count;
        r.final_result = 1'b1;
        expected_reports.push_back(r);
      end
      // Saturate the position at its top value
      if (next_pos < pos_max) next_pos++;
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b1;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b0;
    endfunction

    // Compare one accepted report with the oldest expected one
    function void check_report(result_t got);
      result_t want;
      bit      ok;
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with none expected, expected nothing, actual %h", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      ok = field_ok("result_kind", want.result_kind, got.result_kind);
      ok = field_ok("header_offset", want.header_offset, got.header_offset) & ok;
      ok = field_ok("image_type", want.image_type, got.image_type) & ok;
      ok = field_ok("image_width", want.image_width, got.image_width) & ok;
      ok = field_ok("image_height", want.image_height, got.image_height) & ok;
      ok = field_ok("bits_per_pixel", want.bits_per_pixel, got.bits_per_pixel) & ok;
      ok = field_ok("match_total", want.match_total, got.match_total) & ok;
      ok = field_ok("final_result", want.final_result, got.final_result) & ok;
      if (!ok) mismatches++;
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
// Testbench top: drives byte files into the TGA header stream scanner and checks its reports.
`timescale 1ns / 1ps

module tb_top;
  import tga_hss_pkg::*;
  import tga_scan_check_pkg::*;

  localparam int POS_BITS      = OFFSET_BITS_DEF;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;

  typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;
  logic              s_tuser  = 1'b0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [87:0]       m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int  src_idle    = 31;
  int  sink_idle   = 31;
  int  hold_asked  = 0;
  int  hold_done   = 0;
  int  hold_left   = 0;
  int  bytes_taken = 0;
  bit  sof_pending = 1'b0;
  header_hit_tracker hits;
  result_t seen;

  always #1 clk = ~clk;

  tga_header_stream_scanner_core #(
    .OFFSET_BITS(POS_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Unpack the output item: kind in tuser, final flag in tlast, the rest in tdata
  assign seen = {m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[55:40],
                 m_tdata[71:56], m_tdata[79:72], m_tdata[87:80], m_tlast};

  // Check each accepted report; stall at random or hold off for a long stretch
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) hits.check_report(seen);
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  // Offer one item after a random gap; leave valid high after acceptance
  task automatic send_item(logic [7:0] data, logic sof, logic eof);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= sof;
    s_tlast  <= eof;
    do @(posedge clk); while (!s_tready);
    hits.take_byte(data, sof, eof);
    bytes_taken++;
  endtask

  // Send the next byte of the current file; a pending start flag rides on it
  task automatic send_byte(logic [7:0] data, logic eof = 1'b0);
    send_item(data, sof_pending, eof);
    sof_pending = 1'b0;
  endtask

  task automatic send_header(hdr_bytes_t hb);
    for (int i = 0; i < HDR_LEN; i++) send_byte(hb[i]);
  endtask

  // Pick a dimension inside the current bounds, or outside them when bad is set and they leave room
  function automatic logic [15:0] pick_dim(bit bad);
    cfg_t c;
    c = hits.cfg;
    if (bad) begin
      if (c.min_dimension > 0 && ($urandom_range(1) == 0 || c.max_dimension == 16'hFFFF))
        return 16'($urandom_range(c.min_dimension - 1, 0));
      if (c.max_dimension != 16'hFFFF)
        return 16'($urandom_range(16'hFFFF, c.max_dimension + 1));
    end
    case ($urandom_range(3))
      0: return c.min_dimension;
      1: return c.max_dimension;
      default: return 16'($urandom_range(c.max_dimension, c.min_dimension));
    endcase
  endfunction

  // Build a header that passes under the current settings, or one meant to break rule flaw (0..6)
  function automatic hdr_bytes_t make_header(int flaw);
    hdr_bytes_t hb;
    cfg_t       c;
    logic [15:0] w;
    logic [15:0] h;
    c = hits.cfg;
    for (int i = 0; i < HDR_LEN; i++) hb[i] = 8'($urandom_range(255));
    hb[0] = (flaw == 2 && c.max_id_length != 8'hFF) ?
            8'($urandom_range(255, c.max_id_length + 1)) :
            8'($urandom_range(c.max_id_length, 0));
    hb[1] = (flaw == 0) ? 8'($urandom_range(255, 1)) : CMAP_NONE;
    if (flaw == 1) hb[2] = 8'($urandom_range(255));
    else hb[2] = $urandom_range(1) ? TYPE_TRUECOLOR : TYPE_RLE_TRUECOLOR;
    w = pick_dim(flaw == 3);
    h = pick_dim(flaw == 4);
    {hb[13], hb[12]} = w;
    {hb[15], hb[14]} = h;
    if (flaw == 5) hb[16] = 8'($urandom_range(255));
    else hb[16] = $urandom_range(1) ? BPP_24 : BPP_32;
    if (flaw == 6) hb[17][3:0] = 4'($urandom_range(15));
    else hb[17][3:0] = $urandom_range(1) ? DESC_ORIGIN_BL : DESC_ALPHA_8;
    return hb;
  endfunction

  // One file: mostly with a start flag, good and broken headers with noise, end flag last
  task automatic send_file(int segments);
    sof_pending = ($urandom_range(9) != 0);
    repeat (segments) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_header(make_header(-1));
      end else if (pick < 75) begin
        send_header(make_header($urandom_range(6)));
      end else begin
        repeat ($urandom_range(12, 1)) begin
          send_item(8'($urandom_range(255)), sof_pending || ($urandom_range(49) == 0),
                    $urandom_range(49) == 0);
          sof_pending = 1'b0;
        end
      end
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Drop valid, wait for every expected report, then let the pipeline drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (hits.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    logic [31:0] mask;
    if (idx == REG_SCAN_START) mask = 32'hFFFF_FFFF;
    else if (idx == REG_MIN_DIM || idx == REG_MAX_DIM) mask = 32'h0000_FFFF;
    else mask = 32'h0000_00FF;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    hits.set_reg(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & mask)) begin
      hits.mismatches++;
      $display("%0t: register %s readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, idx.name(), value & mask, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_settings(logic [31:0] start, logic [7:0] limit, logic [15:0] lo,
                                logic [15:0] hi, logic [7:0] id_max);
    settle();
    reg_write(REG_SCAN_START, start);
    reg_write(REG_MAX_MATCHES, limit);
    reg_write(REG_MIN_DIM, lo);
    reg_write(REG_MAX_DIM, hi);
    reg_write(REG_MAX_ID_LEN, id_max);
  endtask

  // End the run when nothing has moved for too long
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pready))
        stall = 0;
      else
        stall++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    hits = new(POS_BITS);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: headers early in a file lie below the start offset and are ignored
    src_idle = 0;
    sof_pending = 1'b1;
    repeat (40) send_byte(8'($urandom_range(255)));
    src_idle = 31;
    send_header(make_header(-1));
    send_byte(8'($urandom_range(255)));
    send_header(make_header(-1));
    send_byte(8'($urandom_range(255)), 1'b1);

    // Limit of three: each rule broken once, then the fourth good header is blocked
    write_settings(32'd0, 8'd3, 16'd16, 16'd1024, 8'd32);
    sof_pending = 1'b1;
    send_header(make_header(-1));
    for (int f = 0; f < 7; f++) send_header(make_header(f));
    repeat (3) send_header(make_header(-1));
    send_byte(8'hFF, 1'b1);

    // Continue past the end without a start flag, then lower the limit below the count
    settle();
    reg_write(REG_MAX_MATCHES, 8'd5);
    send_header(make_header(-1));
    send_byte(8'h00);
    settle();
    reg_write(REG_MAX_MATCHES, 8'd2);
    send_header(make_header(-1));
    send_byte(8'h00, 1'b1);

    // Limit of zero finds nothing
    settle();
    reg_write(REG_MAX_MATCHES, 8'd0);
    sof_pending = 1'b1;
    send_header(make_header(-1));
    send_byte(8'h00, 1'b1);

    // Inverted dimension bounds find nothing
    write_settings(32'd0, 8'd255, 16'd1000, 16'd999, 8'd255);
    sof_pending = 1'b1;
    repeat (2) send_header(make_header(-1));
    send_byte(8'h00, 1'b1);

    // Random files over several settings, the extremes first
    for (int s = 0; s < 7; s++) begin
      int mark;
      int lo;
      lo = $urandom_range(300);
      case (s)
        0: write_settings(32'd0, 8'd255, 16'd0, 16'hFFFF, 8'd255);
        1: write_settings(32'd0, 8'd1, 16'hFFFF, 16'hFFFF, 8'd0);
        2: write_settings(32'hFFFF_FFFF, 8'd255, 16'd0, 16'hFFFF, 8'd255);
        default: write_settings($urandom_range(40), 8'($urandom_range(12, 1)), 16'(lo),
                                16'(lo + $urandom_range(900)), 8'($urandom_range(255)));
      endcase
      // Hold off the receiver while dense headers keep coming, to fill the block
      if (s == 0) hold_asked++;
      if (s == 3) begin
        src_idle  = 0;
        sink_idle = 0;
      end else begin
        src_idle  = 31;
        sink_idle = 31;
      end
      mark = bytes_taken;
      while (bytes_taken - mark < 200) send_file($urandom_range(8, 1));
    end

    settle();
    if (hits.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/tga_hss_pkg.sv
hw/rtl/tga_hss_regs.sv
hw/rtl/tga_hss_scan.sv
hw/rtl/tga_hss_outq.sv
hw/rtl/tga_header_stream_scanner_core.sv
dv/tga_scan_check_pkg.sv
dv/tb_top.sv
